/* rtl/core/wtcp_pkg.sv */
// Shared types and constants of the weighted congestion-window update block.
// Holds the payload structs, the control state enum and the divider status.
// Depends on nothing; every other file in rtl/core uses it.
`default_nettype none

package wtcp_pkg;

    // Default width of the congestion window state.
    localparam int WINDOW_BITS_DEFAULT = 32;

    // Width of the growth numerator w*w*s*s and of the serial quotient.
    localparam int NUM_BITS = 64;

    // The weight is Q1.15, so w*w carries 30 fraction bits.
    localparam int ADDER_LSB = 30;
    localparam int ADDER_BITS = NUM_BITS - ADDER_LSB;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEGMENT_SIZE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLOW_WEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_WINDOW    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_THRESHOLD = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] SEGMENT_SIZE_RESET      = 16'd536;
    localparam logic [15:0] FLOW_WEIGHT_RESET       = 16'd32768;
    localparam logic [31:0] INITIAL_WINDOW_RESET    = 32'd536;
    localparam logic [31:0] INITIAL_THRESHOLD_RESET = 32'hFFFF_FFFF;

    // Input command codes.
    localparam logic CMD_ACK  = 1'b0;
    localparam logic CMD_LOSS = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] segments_acked;
        logic [31:0] bytes_in_flight;
    } wtcp_in_t;

    typedef struct packed {
        logic [31:0] window_bytes;
        logic [31:0] threshold_bytes;
    } wtcp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOW,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_GROW,
        ST_OUT
    } wtcp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wtcp_div_status_t;

endpackage

`default_nettype wire

/* rtl/core/wtcp_sqmul.sv */
// Two-stage multiplier for the growth numerator w*w*s*s.
// Squares weight and segment size, then multiplies the squares.
// Depends on wtcp_pkg.
`default_nettype none

module wtcp_sqmul (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [15:0]                  weight,
    input  wire logic [15:0]                  seg_size,
    output logic      [wtcp_pkg::NUM_BITS-1:0] num,
    output logic                              done
);

    logic [31:0]                   w2_reg;
    logic [31:0]                   s2_reg;
    logic [wtcp_pkg::NUM_BITS-1:0] num_reg;
    logic                          v1_reg;
    logic                          v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
        w2_reg  <= 32'(weight) * 32'(weight);
        s2_reg  <= 32'(seg_size) * 32'(seg_size);
        num_reg <= wtcp_pkg::NUM_BITS'(w2_reg) * wtcp_pkg::NUM_BITS'(s2_reg);
    end

    assign num  = num_reg;
    assign done = v2_reg;

endmodule

`default_nettype wire

/* rtl/core/wtcp_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Divides the 64-bit growth numerator by the window.
// Depends on wtcp_pkg.
`default_nettype none

module wtcp_divider #(
    parameter int WINDOW_BITS = wtcp_pkg::WINDOW_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [wtcp_pkg::NUM_BITS-1:0] dividend,
    input  wire logic [WINDOW_BITS-1:0]        divisor,
    output logic      [wtcp_pkg::NUM_BITS-1:0] quotient,
    output wtcp_pkg::wtcp_div_status_t         status
);

    localparam int CNT_BITS = $clog2(wtcp_pkg::NUM_BITS);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(wtcp_pkg::NUM_BITS - 1);

    logic [wtcp_pkg::NUM_BITS-1:0] q_reg, q_next;
    logic [WINDOW_BITS-1:0]        rem_reg, rem_next;
    logic [WINDOW_BITS-1:0]        div_reg, div_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [WINDOW_BITS:0]          trial;
    logic [WINDOW_BITS+1:0]        diff;

    always_comb begin
        trial     = {rem_reg, q_reg[wtcp_pkg::NUM_BITS-1]};
        diff      = {1'b0, trial} - {2'b00, div_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = LAST_STEP;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // A borrow out of the trial subtraction means this quotient bit is zero.
            if (diff[WINDOW_BITS+1]) begin
                rem_next = trial[WINDOW_BITS-1:0];
                q_next   = {q_reg[wtcp_pkg::NUM_BITS-2:0], 1'b0};
            end else begin
                rem_next = diff[WINDOW_BITS-1:0];
                q_next   = {q_reg[wtcp_pkg::NUM_BITS-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/weighted_tcp_window_update.sv */
// Weighted congestion-window update, top level; depends on wtcp_pkg, wtcp_sqmul, wtcp_divider.
// A loss transaction passes the sequencer states idle, slow and out; an ack transaction
// also passes check, and with congestion-avoidance growth also mul, div and grow, where
// the 64-step bit-serial divider runs. One transaction is in work at a time: a new one is
// taken only back in idle, and the out state holds while the result side is not ready.
// Synchronous active-low reset loads window and threshold from the register reset values.
`default_nettype none

module weighted_tcp_window_update #(
    parameter int WINDOW_BITS = wtcp_pkg::WINDOW_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_we,
    input  wire logic [wtcp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [wtcp_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire wtcp_pkg::wtcp_in_t                  s_payload,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output wtcp_pkg::wtcp_out_t                      m_payload
);

    // The saturating adder must hold the window plus the widest addend (the
    // growth term, ADDER_BITS wide) without wrapping.
    localparam int SUM_W = ((WINDOW_BITS > wtcp_pkg::ADDER_BITS) ?
                            WINDOW_BITS : wtcp_pkg::ADDER_BITS) + 1;
    // Compare width for window against the 32-bit threshold.
    localparam int CMP_W = (WINDOW_BITS > 32) ? WINDOW_BITS : 32;

    // Configuration registers. The initial window and threshold values are only
    // loaded into the state, so they need no storage of their own.
    logic [15:0] seg_size_reg, seg_size_next;
    logic [15:0] weight_reg, weight_next;

    // Congestion state.
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [31:0]            threshold_reg, threshold_next;

    // The transaction under work.
    wtcp_pkg::wtcp_state_t state_reg, state_next;
    logic        cmd_reg, cmd_next;
    logic [15:0] acked_reg, acked_next;
    logic [31:0] flight_reg, flight_next;

    // Output register. It frees the input side while a result waits to be taken.
    logic                m_valid_reg, m_valid_next;
    wtcp_pkg::wtcp_out_t out_reg, out_next;

    // Handshake and sequencing strobes.
    logic out_free;
    logic out_load;
    logic mul_start;
    logic div_start;
    logic grow_cond;

    // Arithmetic helpers.
    logic [wtcp_pkg::NUM_BITS-1:0]   num;
    logic                            mul_done;
    logic [wtcp_pkg::NUM_BITS-1:0]   quotient;
    wtcp_pkg::wtcp_div_status_t      div_status;
    logic [WINDOW_BITS-1:0]          divisor;
    logic [wtcp_pkg::ADDER_BITS-1:0] growth;
    logic [SUM_W-1:0]                addend;
    logic [SUM_W-1:0]                sum;
    logic [WINDOW_BITS-1:0]          sat_sum;
    logic [CMP_W-1:0]                win_ext;
    logic                            win_below;
    logic [16:0]                     two_seg;
    logic [30:0]                     half_flight;

    wtcp_sqmul u_sqmul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .weight   (weight_reg),
        .seg_size (seg_size_reg),
        .num      (num),
        .done     (mul_done)
    );

    // A zero window divides by one instead.
    assign divisor = (window_reg == '0) ? WINDOW_BITS'(1) : window_reg;

    wtcp_divider #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    always_comb begin
        // The growth term drops the 30 fraction bits of the weight square and is
        // never less than one byte.
        growth = quotient[wtcp_pkg::NUM_BITS-1:wtcp_pkg::ADDER_LSB];
        if (growth == '0) begin
            growth = wtcp_pkg::ADDER_BITS'(1);
        end

        // One saturating adder serves slow start and congestion avoidance.
        addend = (state_reg == wtcp_pkg::ST_GROW) ? SUM_W'(growth) : SUM_W'(seg_size_reg);
        sum    = SUM_W'(window_reg) + addend;
        if (sum[SUM_W-1:WINDOW_BITS] != '0) begin
            sat_sum = '1;
        end else begin
            sat_sum = sum[WINDOW_BITS-1:0];
        end

        win_ext     = CMP_W'(window_reg);
        win_below   = win_ext < CMP_W'(threshold_reg);
        grow_cond   = !win_below && (acked_reg != '0);
        two_seg     = {seg_size_reg, 1'b0};
        half_flight = flight_reg[31:1];
        out_free    = !m_valid_reg || m_ready;
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wtcp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = wtcp_pkg::ST_SLOW;
                end
            end
            wtcp_pkg::ST_SLOW: begin
                if (cmd_reg == wtcp_pkg::CMD_LOSS) begin
                    state_next = wtcp_pkg::ST_OUT;
                end else begin
                    state_next = wtcp_pkg::ST_CHECK;
                end
            end
            wtcp_pkg::ST_CHECK: begin
                if (grow_cond) begin
                    state_next = wtcp_pkg::ST_MUL;
                end else begin
                    state_next = wtcp_pkg::ST_OUT;
                end
            end
            wtcp_pkg::ST_MUL: begin
                if (mul_done) begin
                    state_next = wtcp_pkg::ST_DIV;
                end
            end
            wtcp_pkg::ST_DIV: begin
                if (div_status.done) begin
                    state_next = wtcp_pkg::ST_GROW;
                end
            end
            wtcp_pkg::ST_GROW: begin
                state_next = wtcp_pkg::ST_OUT;
            end
            wtcp_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = wtcp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wtcp_pkg::ST_IDLE;
            end
        endcase
    end

    // Strobes of the sequencer.
    always_comb begin
        s_ready   = (state_reg == wtcp_pkg::ST_IDLE);
        mul_start = (state_reg == wtcp_pkg::ST_CHECK) && grow_cond;
        div_start = (state_reg == wtcp_pkg::ST_MUL) && mul_done;
        out_load  = (state_reg == wtcp_pkg::ST_OUT) && out_free;
    end

    // Datapath and register updates.
    always_comb begin
        seg_size_next  = seg_size_reg;
        weight_next    = weight_reg;
        window_next    = window_reg;
        threshold_next = threshold_reg;
        cmd_next       = cmd_reg;
        acked_next     = acked_reg;
        flight_next    = flight_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        if (s_valid && s_ready) begin
            cmd_next    = s_payload.cmd;
            acked_next  = s_payload.segments_acked;
            flight_next = s_payload.bytes_in_flight;
        end

        if (state_reg == wtcp_pkg::ST_SLOW) begin
            if (cmd_reg == wtcp_pkg::CMD_LOSS) begin
                // The threshold falls to half the bytes in flight, but never
                // below two segments.
                if (32'(two_seg) > 32'(half_flight)) begin
                    threshold_next = 32'(two_seg);
                end else begin
                    threshold_next = 32'(half_flight);
                end
            end else if (win_below && (acked_reg != '0)) begin
                // Slow start spends one acked segment.
                window_next = sat_sum;
                acked_next  = acked_reg - 1'b1;
            end
        end

        if (state_reg == wtcp_pkg::ST_GROW) begin
            window_next = sat_sum;
        end

        if (out_load) begin
            out_next.window_bytes    = win_ext[31:0];
            out_next.threshold_bytes = threshold_reg;
            m_valid_next             = 1'b1;
        end

        // The user must write only while no transaction is in work; the block itself does not enforce it.
        if (cfg_we) begin
            case (cfg_index)
                wtcp_pkg::CFG_SEGMENT_SIZE: begin
                    seg_size_next = cfg_data[15:0];
                end
                wtcp_pkg::CFG_FLOW_WEIGHT: begin
                    weight_next = cfg_data[15:0];
                end
                wtcp_pkg::CFG_INITIAL_WINDOW: begin
                    window_next = WINDOW_BITS'(cfg_data);
                end
                wtcp_pkg::CFG_INITIAL_THRESHOLD: begin
                    threshold_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wtcp_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            seg_size_reg  <= wtcp_pkg::SEGMENT_SIZE_RESET;
            weight_reg    <= wtcp_pkg::FLOW_WEIGHT_RESET;
            window_reg    <= WINDOW_BITS'(wtcp_pkg::INITIAL_WINDOW_RESET);
            threshold_reg <= wtcp_pkg::INITIAL_THRESHOLD_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            seg_size_reg  <= seg_size_next;
            weight_reg    <= weight_next;
            window_reg    <= window_next;
            threshold_reg <= threshold_next;
        end
        cmd_reg    <= cmd_next;
        acked_reg  <= acked_next;
        flight_reg <= flight_next;
        out_reg    <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // The divider only reports completion while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == wtcp_pkg::ST_DIV))
        else $error("divider finished outside the division state");

    // A new result appears only as the output state hands it over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == wtcp_pkg::ST_OUT))
        else $error("result became valid outside the output state");

    // After a loss transaction the threshold is at least two segments.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wtcp_pkg::ST_SLOW) && (cmd_reg == wtcp_pkg::CMD_LOSS)
        |=> (threshold_reg >= 32'({seg_size_reg, 1'b0})))
        else $error("threshold below two segments after loss");

endmodule

`default_nettype wire

/* bench/weighted_tcp_window_update_test.sv */
// Self-checking bench for the weighted congestion-window update block.
// Predicts window and threshold per transaction and compares every result in order.
// Depends on wtcp_pkg and weighted_tcp_window_update.

module weighted_tcp_window_update_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wtcp_pkg::*;

    localparam int WIN_W = 32;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 9;
    // Covers even the slowest transaction, so any trailing result shows up.
    localparam int SETTLE_CYCLES = 80;
    // Cycles without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;
    // Q1.15 times Q1.15 leaves 30 fraction bits in the growth numerator.
    localparam int WEIGHT_SQ_FRAC = 30;
    localparam logic [63:0] WIN_LIMIT = ((64'd1 << (WIN_W - 1)) << 1) - 64'd1;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    wtcp_in_t                  s_payload;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    wtcp_out_t                 m_payload;

    weighted_tcp_window_update #(
        .WINDOW_BITS(WIN_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Shadow copy of the block's registers and state, kept in step with every
    // accepted transaction and every register write.
    logic [15:0] mss;
    logic [15:0] weight;
    logic [63:0] cwnd;
    logic [31:0] ssthresh;

    // Results the block still owes, oldest first.
    wtcp_out_t window_update_queue[$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          idle_enable = 1'b1;

    // Every addition to the window clips at the largest value the window holds.
    function automatic logic [63:0] add_saturating(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] sum;
        sum = a + b;
        if (sum < a || sum > WIN_LIMIT) begin
            return WIN_LIMIT;
        end
        return sum;
    endfunction

    // Advances the shadow state by one transaction and returns the result the
    // block must produce for it.
    function automatic wtcp_out_t compute_window_update(input wtcp_in_t item);
        logic [63:0] acked;
        logic [63:0] mss64;
        logic [63:0] wt64;
        logic [63:0] numer;
        logic [63:0] divisor;
        logic [63:0] growth;
        logic [63:0] two_mss;
        logic [63:0] half_flight;
        wtcp_out_t   res;
        acked = {48'd0, item.segments_acked};
        mss64 = {48'd0, mss};
        wt64 = {48'd0, weight};
        if (item.cmd == CMD_ACK) begin
            // Slow start consumes at most one acked segment per transaction.
            if (cwnd < {32'd0, ssthresh} && acked != 0) begin
                cwnd = add_saturating(cwnd, mss64);
                acked = acked - 1;
            end
            // Congestion avoidance: one weighted increment, never less than a byte.
            if (cwnd >= {32'd0, ssthresh} && acked != 0) begin
                numer = (wt64 * wt64) * (mss64 * mss64);
                divisor = (cwnd != 0) ? cwnd : 64'd1;
                growth = (numer / divisor) >> WEIGHT_SQ_FRAC;
                if (growth == 0) begin
                    growth = 64'd1;
                end
                cwnd = add_saturating(cwnd, growth);
            end
        end else begin
            two_mss = 64'd2 * mss64;
            half_flight = {32'd0, item.bytes_in_flight} >> 1;
            ssthresh = (two_mss > half_flight) ? two_mss[31:0] : half_flight[31:0];
        end
        res.window_bytes = cwnd[31:0];
        res.threshold_bytes = ssthresh;
        return res;
    endfunction

    function automatic wtcp_in_t make_event(input logic cmd, input logic [15:0] acked,
                                            input logic [31:0] flight);
        wtcp_in_t item;
        item.cmd = cmd;
        item.segments_acked = acked;
        item.bytes_in_flight = flight;
        return item;
    endfunction

    // Random transaction. Acks mostly carry the counts that steer the two growth
    // rules (zero, one, a few); half the losses report a flight near the current
    // window so that the threshold lands where avoidance actually kicks in.
    function automatic wtcp_in_t random_event();
        wtcp_in_t item;
        int       pick;
        item.cmd = ($urandom_range(0, 99) < 72) ? CMD_ACK : CMD_LOSS;
        item.segments_acked = 16'($urandom);
        item.bytes_in_flight = $urandom;
        pick = $urandom_range(0, 19);
        if (item.cmd == CMD_ACK) begin
            if (pick == 0) begin
                item.segments_acked = 16'd0;
            end else if (pick < 10) begin
                item.segments_acked = 16'd1;
            end else if (pick < 17) begin
                item.segments_acked = 16'($urandom_range(2, 8));
            end
        end else begin
            if (pick < 10) begin
                item.bytes_in_flight = cwnd[31:0] - $urandom_range(0, cwnd[31:0] >> 2);
            end else if (pick < 15) begin
                item.bytes_in_flight = $urandom_range(0, 4 * mss);
            end
        end
        return item;
    endfunction

    // Presents one transaction, optionally after a short idle burst, and returns
    // in the time step in which it is accepted. Valid stays high on return; the
    // next call or the drain decides what it does next.
    task automatic send_event(input wtcp_in_t item);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= item;
        window_update_queue.push_back(compute_window_update(item));
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Holds off the sender until the block has delivered everything it owes.
    task automatic wait_for_results_drained();
        s_valid <= 1'b0;
        while (window_update_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
    endtask

    // Writes all four registers while the block is idle. Writing the initial
    // window and threshold also reloads the live state, so the shadow follows.
    task automatic configure(input logic [15:0] seg, input logic [15:0] wt,
                             input logic [31:0] init_window, input logic [31:0] init_thresh);
        wait_for_results_drained();
        write_register(CFG_SEGMENT_SIZE, {16'd0, seg});
        write_register(CFG_FLOW_WEIGHT, {16'd0, wt});
        write_register(CFG_INITIAL_WINDOW, init_window);
        write_register(CFG_INITIAL_THRESHOLD, init_thresh);
        cfg_we <= 1'b0;
        mss = seg;
        weight = wt;
        cwnd = {32'd0, init_window} & WIN_LIMIT;
        ssthresh = init_thresh;
        @(posedge aclk);
    endtask

    task automatic run_random_phase(input int count, input bit with_pause);
        for (int i = 0; i < count; i++) begin
            if (with_pause && i == count / 2) begin
                wait_for_results_drained();
            end
            send_event(random_event());
        end
    endtask

    // Straight out of reset: no-op ack, single slow-start step, a huge count that
    // still takes only one step, then both loss extremes.
    task automatic test_reset_values();
        send_event(make_event(CMD_ACK, 16'd0, 32'hFFFF_FFFF));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        send_event(make_event(CMD_ACK, 16'hFFFF, 32'h5555_AAAA));
        send_event(make_event(CMD_LOSS, 16'hFFFF, 32'd0));
        send_event(make_event(CMD_LOSS, 16'd0, 32'hFFFF_FFFF));
    endtask

    // Slow start that reaches the threshold exactly, then weighted growth, then a
    // loss that lifts the threshold back above the window.
    task automatic test_congestion_avoidance();
        configure(16'd1460, 16'd32768, 32'd2920, 32'd4380);
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        send_event(make_event(CMD_ACK, 16'd3, 32'd0));
        send_event(make_event(CMD_ACK, 16'hFFFF, 32'd0));
        send_event(make_event(CMD_LOSS, 16'd0, 32'h0001_0000));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
    endtask

    // A zero window must divide by one instead of zero.
    task automatic test_zero_window();
        configure(16'd536, 16'd32768, 32'd0, 32'd0);
        send_event(make_event(CMD_ACK, 16'd0, 32'd0));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        send_event(make_event(CMD_ACK, 16'd2, 32'd0));
    endtask

    // A zero segment size stalls slow start and makes the growth term one byte.
    task automatic test_zero_segment_size();
        configure(16'd0, 16'd32768, 32'd100, 32'd1000);
        send_event(make_event(CMD_ACK, 16'd2, 32'd0));
        send_event(make_event(CMD_LOSS, 16'd0, 32'd1));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
    endtask

    // Largest segment and weight above 1.0 push the window into saturation, both
    // from avoidance and from slow start.
    task automatic test_saturation();
        configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FF00, 32'd0);
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        configure(16'hFFFF, 16'hFFFF, 32'd1, 32'd0);
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
        configure(16'hFFFF, 16'd32768, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_event(make_event(CMD_ACK, 16'd2, 32'd0));
        configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
    endtask

    // Zero weight: the growth term collapses to the one-byte floor.
    task automatic test_zero_weight();
        configure(16'd1460, 16'd0, 32'd10000, 32'd5000);
        send_event(make_event(CMD_ACK, 16'd2, 32'd0));
        send_event(make_event(CMD_ACK, 16'd1, 32'd0));
    endtask

    task automatic test_random_default();
        configure(SEGMENT_SIZE_RESET, FLOW_WEIGHT_RESET, INITIAL_WINDOW_RESET,
                  INITIAL_THRESHOLD_RESET);
        run_random_phase(300, 1'b0);
    endtask

    // Typical link with a fractional weight; the sender stalls once mid-phase
    // until every result is back.
    task automatic test_random_ethernet();
        configure(16'd1460, 16'($urandom_range(1, 32768)), $urandom_range(1, 20000),
                  $urandom_range(3000, 200000));
        run_random_phase(300, 1'b1);
    endtask

    task automatic test_random_full_range();
        configure(16'($urandom), 16'($urandom), $urandom, $urandom);
        run_random_phase(300, 1'b0);
    endtask

    task automatic test_random_tiny_segments();
        configure(16'd1, 16'd32768, 32'd1, 32'd0);
        run_random_phase(200, 1'b0);
    endtask

    task automatic test_random_saturating();
        configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF - $urandom_range(0, 1 << 20), $urandom);
        run_random_phase(200, 1'b0);
    endtask

    // Last stretch runs with both sides always willing.
    task automatic test_random_no_idling();
        configure(16'($urandom_range(500, 9000)), 16'($urandom_range(16384, 49152)),
                  $urandom_range(1000, 100000), 32'hFFFF_FFFF);
        idle_enable = 1'b0;
        run_random_phase(400, 1'b0);
    endtask

    // Result side: ready drops at random while idling is on.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every accepted result transaction is matched against the oldest prediction.
    always @(posedge aclk) begin : check_result
        wtcp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (window_update_queue.size() == 0) begin
                $error("unexpected result: window_bytes %h threshold_bytes %h",
                       m_payload.window_bytes, m_payload.threshold_bytes);
                mismatch_count++;
            end else begin
                want = window_update_queue.pop_front();
                if (m_payload.window_bytes !== want.window_bytes) begin
                    $error("window_bytes: expected %h, actual %h",
                           want.window_bytes, m_payload.window_bytes);
                    mismatch_count++;
                end
                if (m_payload.threshold_bytes !== want.threshold_bytes) begin
                    $error("threshold_bytes: expected %h, actual %h",
                           want.threshold_bytes, m_payload.threshold_bytes);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detector: any handshake on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("weighted_tcp_window_update regression: fail");
                $finish;
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SEGMENT_SIZE;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_payload <= '0;
        mss = SEGMENT_SIZE_RESET;
        weight = FLOW_WEIGHT_RESET;
        cwnd = {32'd0, INITIAL_WINDOW_RESET} & WIN_LIMIT;
        ssthresh = INITIAL_THRESHOLD_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_congestion_avoidance();
        test_zero_window();
        test_zero_segment_size();
        test_saturation();
        test_zero_weight();
        test_random_default();
        test_random_ethernet();
        test_random_full_range();
        test_random_tiny_segments();
        test_random_saturating();
        test_random_no_idling();

        // Let the last transaction finish, then watch for any stray result.
        s_valid <= 1'b0;
        while (window_update_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("weighted_tcp_window_update regression: pass");
        end else begin
            $display("weighted_tcp_window_update regression: fail");
        end
        $finish;
    end

endmodule
